@@ rtl/core/bounded_sorted_priority_list_core_defines.svh @@
// Assertion macros used by the checker file
`ifndef BOUNDED_SORTED_PRIORITY_LIST_CORE_DEFINES_SVH
`define BOUNDED_SORTED_PRIORITY_LIST_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define BSPL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bspl check failed");

// next-cycle implication, sampled on clk, off during reset
`define BSPL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bspl check failed");

`endif

@@ rtl/core/bspl_pkg.sv @@
package bspl_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int AGE_W       = 8;
    localparam int ID_W        = 16;
    localparam int CNT_W       = 5;

    typedef struct packed {
        logic [AGE_W-1:0] age;
        logic [ID_W-1:0]  id;
    } entry_t;

    typedef struct packed {
        logic [AGE_W-1:0] new_age;
        logic [ID_W-1:0]  new_id;
    } item_t;

    typedef struct packed {
        logic             evicted_valid;
        logic [AGE_W-1:0] evicted_age;
        logic [ID_W-1:0]  evicted_id;
        logic [AGE_W-1:0] lowest_age;
        logic [ID_W-1:0]  lowest_id;
        logic [CNT_W-1:0] entry_count;
        logic             is_full;
    } result_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic   load;
        logic   evict;
        entry_t ent;
    } cell_ctl_t;

    // a sorts before b: smaller age, or same age and larger id
    function automatic logic lower_than(entry_t a, entry_t b);
        lower_than = (a.age < b.age) || ((a.age == b.age) && (a.id > b.id));
    endfunction

endpackage

@@ rtl/core/bspl_cell.sv @@
module bspl_cell (
    input  logic               clk,
    input  bspl_pkg::cell_ctl_t ctl,
    input  logic               first,
    input  logic               beyond,
    input  logic               prev_g,
    input  bspl_pkg::entry_t   prev_ent,
    input  logic               next_g,
    input  bspl_pkg::entry_t   next_ent,
    output bspl_pkg::entry_t   ent,
    output bspl_pkg::entry_t   ent_next,
    output logic               g
);
    import bspl_pkg::*;

    entry_t ent_reg;
    entry_t ent_next_w;

    // offered item sorts below this slot, or the slot is empty
    assign g = beyond || lower_than(ctl.ent, ent_reg);

    // insert: shift up above the insert point; evict: shift down below it
    always_comb
    begin
        if (!ctl.evict)
        begin
            if (g)
                ent_next_w = prev_g ? prev_ent : ctl.ent;
            else
                ent_next_w = ent_reg;
        end
        else
        begin
            if (next_g)
                ent_next_w = (g && !first) ? ent_reg : ctl.ent;
            else
                ent_next_w = next_ent;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
            ent_reg <= ent_next_w;
    end

    assign ent      = ent_reg;
    assign ent_next = ent_next_w;

endmodule

@@ rtl/core/bounded_sorted_priority_list_core.sv @@
// The result is strobed on done in the cycle after start is taken.
// Throughput: one item per cycle; busy stays low, all cells shift in parallel.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset (rst_n low, async): list empty, capacity 16, no result pending.
// Entry storage is not cleared; only slots below the count are ever read.
module bounded_sorted_priority_list_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  bspl_pkg::item_t           item,
    output logic                      done,
    output bspl_pkg::result_t         result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [bspl_pkg::CNT_W-1:0] cfg_data
);
    import bspl_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] cap_reg;
    logic [CNT_W-1:0] eff_cap;
    logic             done_reg;
    result_t          res_reg, res_next;
    logic             accept;
    logic             full;
    cell_ctl_t        ctl;

    entry_t ent      [MAX_ENTRIES];
    entry_t ent_next [MAX_ENTRIES];
    logic   g        [MAX_ENTRIES];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // clamp the capacity register to 1..MAX_ENTRIES
    always_comb
    begin
        if (cap_reg == '0)
            eff_cap = CNT_W'(1);
        else if (cap_reg > CNT_W'(MAX_ENTRIES))
            eff_cap = CNT_W'(MAX_ENTRIES);
        else
            eff_cap = cap_reg;
    end

    assign full      = (cnt_reg >= eff_cap);
    assign ctl.load  = accept;
    assign ctl.evict = full;
    assign ctl.ent   = '{age: item.new_age, id: item.new_id};

    // row of cells
    genvar i;
    generate
        for (i = 0; i < MAX_ENTRIES; i++)
        begin : g_cell
            logic   p_g, n_g;
            entry_t p_ent, n_ent;
            if (i == 0)
            begin : g_head
                assign p_g   = 1'b0;
                assign p_ent = '0;
            end
            else
            begin : g_mid
                assign p_g   = g[i-1];
                assign p_ent = ent[i-1];
            end
            if (i == MAX_ENTRIES - 1)
            begin : g_tail
                assign n_g   = 1'b1;
                assign n_ent = '0;
            end
            else
            begin : g_body
                assign n_g   = g[i+1];
                assign n_ent = ent[i+1];
            end
            bspl_cell u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .first    (i == 0),
                .beyond   (cnt_reg <= CNT_W'(i)),
                .prev_g   (p_g),
                .prev_ent (p_ent),
                .next_g   (n_g),
                .next_ent (n_ent),
                .ent      (ent[i]),
                .ent_next (ent_next[i]),
                .g        (g[i])
            );
        end
    endgenerate

    // count and result for the item being taken
    always_comb
    begin
        cnt_next               = full ? cnt_reg : cnt_reg + CNT_W'(1);
        res_next.evicted_valid = full;
        res_next.evicted_age   = full ? ent[0].age : '0;
        res_next.evicted_id    = full ? ent[0].id : '0;
        res_next.lowest_age    = ent_next[0].age;
        res_next.lowest_id     = ent_next[0].id;
        res_next.entry_count   = cnt_next;
        res_next.is_full       = (cnt_next >= eff_cap);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            cap_reg  <= CNT_W'(MAX_ENTRIES);
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
                cnt_reg <= cnt_next;
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

@@ rtl/core/bspl_checker.sv @@
`include "bounded_sorted_priority_list_core_defines.svh"

module bspl_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input bspl_pkg::item_t            item,
    input logic                       done,
    input bspl_pkg::result_t          result,
    input logic                       cfg_valid,
    input logic                       cfg_ready,
    input logic [bspl_pkg::CNT_W-1:0] cfg_data
);
    import bspl_pkg::*;

    // exactly one result per taken item, in the next cycle
    `BSPL_ASSERT_NEXT(a_done_follows, start && !busy, done)
    `BSPL_ASSERT_NEXT(a_no_stray_done, !(start && !busy), !done)
    // eviction only happens on a full list
    `BSPL_ASSERT_NOW(a_evict_full, done && result.evicted_valid, result.is_full)
    // list is never empty after an item, and no evicted data without eviction
    `BSPL_ASSERT_NOW(a_quiet_evict, done && !result.evicted_valid,
        result.evicted_age == '0 && result.evicted_id == '0 && result.entry_count != '0)

endmodule

bind bounded_sorted_priority_list_core bspl_checker u_bspl_checker (.*);

@@ test/bounded_sorted_priority_list_core_test.sv @@
module bounded_sorted_priority_list_core_test;
    import bspl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 4;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    item_t item = '0;
    logic done;
    result_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CNT_W-1:0] cfg_data = '0;

    // items waiting to be offered, and list states still to come back
    item_t pending_items[$];
    result_t expected_results[$];

    // shadow of the list, its count and the capacity register
    entry_t shadow_list[MAX_ENTRIES];
    int shadow_count = 0;
    logic [CNT_W-1:0] shadow_capacity = 5'd16;

    int mismatches = 0;
    int cycle_count = 0;
    int gap_left = 0;
    logic no_idle = 1'b0;

    bounded_sorted_priority_list_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .done(done),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // a sorts strictly before b: smaller age, or same age and larger id
    function automatic logic sorts_below(entry_t a, entry_t b);
        return (a.age < b.age) || ((a.age == b.age) && (a.id > b.id));
    endfunction

    // put an entry among sorted slots 0..n-1 of the shadow list, which then fill 0..n, keeping the order
    function automatic void shadow_place(entry_t e, int n);
        int pos;
        pos = n;
        while (pos > 0 && sorts_below(e, shadow_list[pos-1]))
        begin
            shadow_list[pos] = shadow_list[pos-1];
            pos--;
        end
        shadow_list[pos] = e;
    endfunction

    // apply one offered entry to the shadow list and return the list state after it
    function automatic result_t offer_entry(item_t it);
        result_t r;
        entry_t e;
        int limit;
        r = '0;
        e.age = it.new_age;
        e.id = it.new_id;
        limit = (shadow_capacity == 0) ? 1 :
                (shadow_capacity > MAX_ENTRIES) ? MAX_ENTRIES : int'(shadow_capacity);
        if (shadow_count < limit)
        begin
            shadow_place(e, shadow_count);
            shadow_count++;
        end
        else
        begin
            // full, or capacity lowered below the count: drop slot 0
            r.evicted_valid = 1'b1;
            r.evicted_age = shadow_list[0].age;
            r.evicted_id = shadow_list[0].id;
            for (int i = 1; i < shadow_count; i++)
                shadow_list[i-1] = shadow_list[i];
            shadow_place(e, shadow_count - 1);
        end
        r.lowest_age = shadow_list[0].age;
        r.lowest_id = shadow_list[0].id;
        r.entry_count = CNT_W'(shadow_count);
        r.is_full = (shadow_count >= limit);
        return r;
    endfunction

    // random entry, biased toward ties, duplicates and extremes
    function automatic item_t random_item();
        item_t it;
        case ($urandom_range(0, 3))
            0:
            begin
                it.new_age = AGE_W'($urandom);
                it.new_id = ID_W'($urandom);
            end
            1:
            begin
                it.new_age = AGE_W'($urandom_range(100, 103));
                it.new_id = ID_W'($urandom_range(0, 3));
            end
            2:
            begin
                it.new_age = $urandom_range(0, 1) ? '1 : '0;
                it.new_id = $urandom_range(0, 1) ? '1 : ID_W'($urandom);
            end
            default:
            begin
                it.new_age = AGE_W'($urandom_range(0, 15));
                it.new_id = ID_W'($urandom);
            end
        endcase
        return it;
    endfunction

    function automatic item_t make_item(int age, int id);
        item_t it;
        it.new_age = AGE_W'(age);
        it.new_id = ID_W'(id);
        return it;
    endfunction

    // append an item to the queue of pending offers
    function automatic void add_item(item_t it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    // driver: offers queued items with random gaps, predicts on each accept
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            item <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
                expected_results.insert(expected_results.size(), offer_entry(item));
            if (start && busy)
                start <= 1'b1;
            else if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_items.size() > 0)
            begin
                item <= pending_items.pop_front();
                start <= 1'b1;
                // occasionally switch between gapped and back-to-back offers
                if ($urandom_range(0, 39) == 0)
                    no_idle <= ~no_idle;
                gap_left <= no_idle ? 0 : $urandom_range(0, 7);
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: each strobed result against the oldest expected list state
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %p", result);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.evicted_valid !== want.evicted_valid
                    || result.evicted_age !== want.evicted_age
                    || result.evicted_id !== want.evicted_id
                    || result.lowest_age !== want.lowest_age
                    || result.lowest_id !== want.lowest_id
                    || result.entry_count !== want.entry_count
                    || result.is_full !== want.is_full)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, result);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // wait until every offered item is taken and every result is back
    task automatic drain();
        do
            @(posedge clk);
        while (pending_items.size() > 0 || start || expected_results.size() > 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        shadow_capacity = value;
        cfg_valid <= 1'b0;
        cfg_data <= CNT_W'($urandom);
        @(posedge clk);
    endtask

    task automatic random_phase(input logic [CNT_W-1:0] cap, input int n);
        write_capacity(cap);
        for (int i = 0; i < n; i++)
            add_item(random_item());
        drain();
    endtask

    // stimulus sequence
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset capacity: inserts with room, extremes, ties and duplicates
        add_item(make_item(128, 100));
        add_item(make_item(255, 16'hFFFF));
        add_item(make_item(0, 0));
        add_item(make_item(0, 16'hFFFF));
        add_item(make_item(128, 200));
        add_item(make_item(128, 100));
        add_item(make_item(255, 0));
        add_item(make_item(128, 50));
        drain();

        // zero acts as one, count already above it: each entry evicts slot 0
        write_capacity(5'd0);
        add_item(make_item(0, 16'hFFFF));
        add_item(make_item(0, 0));
        add_item(make_item(255, 16'hFFFF));
        add_item(make_item(1, 1));
        drain();

        write_capacity(5'd1);
        add_item(make_item(200, 7));
        add_item(make_item(200, 7));
        add_item(make_item(0, 0));
        drain();

        // above the maximum acts as the maximum: fill up, then evict
        write_capacity(5'd31);
        for (int i = 0; i < 9; i++)
            add_item(make_item(60 - i, i));
        add_item(make_item(0, 16'hFFFF));
        drain();

        random_phase(5'd16, 200);
        random_phase(5'd2, 100);
        random_phase(5'd17, 300);
        random_phase(5'd31, 200);
        for (int k = 0; k < 3; k++)
            random_phase(CNT_W'($urandom_range(0, 31)), 150);
        random_phase(5'd16, 100);

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
